// File: rtl/mmpd_pkg.sv
// Shared types, constants and the sample decoder for the min/max peak detector.
`timescale 1ns / 1ps
`default_nettype none
package mmpd_pkg;

    // Fixed field widths.
    localparam int RAW_W        = 24;
    localparam int SAMPLE_W     = 16;
    localparam int LEVEL_W      = 16;
    localparam int CHANNEL_W    = 3;
    localparam int OUT_CNT_W    = 32;
    localparam int BSIZE_W      = 16;
    localparam int CHCFG_W      = 4;
    localparam int SBYTES_W     = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 120;
    localparam int OUT_FIELDS_W = CHANNEL_W + 2 * SAMPLE_W + 2 * OUT_CNT_W + LEVEL_W;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_CHANNELS = 8;
    localparam int DEF_COUNT_WIDTH  = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BYTES  = 2'd2;

    // Configuration reset values.
    localparam logic [BSIZE_W-1:0]  RST_BLOCK_SIZE    = 16'd256;
    localparam logic [CHCFG_W-1:0]  RST_CHANNEL_COUNT = 4'd1;
    localparam logic [SBYTES_W-1:0] RST_SAMPLE_BYTES  = 2'd2;

    // Sample format codes.
    localparam logic [SBYTES_W-1:0] SB_8BIT  = 2'd1;
    localparam logic [SBYTES_W-1:0] SB_16BIT = 2'd2;
    localparam logic [SBYTES_W-1:0] SB_24BIT = 2'd3;

    // Block-wide values carried with each finished block.
    typedef struct packed {
        logic [OUT_CNT_W-1:0] block_number;
        logic [OUT_CNT_W-1:0] loudest_frame;
        logic [LEVEL_W-1:0]   loudest_level;
    } t_blk_info;

    // Decode raw sample bytes into a signed 16-bit value. Unknown widths
    // decode as 8-bit offset binary.
    function automatic logic signed [SAMPLE_W-1:0] decode_sample(
        input logic [RAW_W-1:0]    raw,
        input logic [SBYTES_W-1:0] sbytes
    );
        logic signed [SAMPLE_W-1:0] q;
        q = '0;
        case (sbytes)
            SB_16BIT: begin
                q = raw[15:0];
            end
            SB_24BIT: begin
                // Arithmetic shift floors; bump negatives with a remainder
                // so the result truncates toward zero.
                q = raw[23:8];
                if (raw[23] && (raw[7:0] != 8'd0)) begin
                    q = q + 16'sd1;
                end
            end
            default: begin
                // Flipping the top bit turns offset binary into two's complement.
                q = {{8{~raw[7]}}, ~raw[7], raw[6:0]};
            end
        endcase
        return q;
    endfunction

endpackage
`default_nettype wire

// File: rtl/mmpd_fifo.sv
// Short queue of finished block records between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module mmpd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty,
    output logic                  o_full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_count == CNT_W'(0));
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/mmpd_front.sv
// Front part: decodes samples, updates per-channel peaks and counters, closes blocks.
`timescale 1ns / 1ps
`default_nettype none
module mmpd_front #(
    parameter int MAX_CHANNELS = 8,
    parameter int COUNT_WIDTH  = 32,
    parameter int CNT_W        = $clog2(MAX_CHANNELS + 1)
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic [mmpd_pkg::BSIZE_W-1:0]            i_block_size,
    input  wire logic [mmpd_pkg::CHCFG_W-1:0]            i_channel_count,
    input  wire logic [mmpd_pkg::SBYTES_W-1:0]           i_sample_bytes,
    input  wire logic                                    i_valid,
    input  wire logic [mmpd_pkg::RAW_W-1:0]              i_raw_sample,
    input  wire logic                                    i_q_full,
    output logic                                         o_ready,
    output logic                                         o_push,
    output logic [MAX_CHANNELS-1:0][mmpd_pkg::SAMPLE_W-1:0] o_high,
    output logic [MAX_CHANNELS-1:0][mmpd_pkg::SAMPLE_W-1:0] o_low,
    output mmpd_pkg::t_blk_info                          o_info,
    output logic [CNT_W-1:0]                             o_chans
);
    import mmpd_pkg::*;

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CMP_W = (CNT_W > CHCFG_W) ? CNT_W : CHCFG_W;
    localparam int EXT_W = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;

    logic signed [SAMPLE_W-1:0] r_high [MAX_CHANNELS];
    logic signed [SAMPLE_W-1:0] r_low  [MAX_CHANNELS];
    logic [BSIZE_W-1:0]         r_fib;
    logic [CH_W-1:0]            r_ch;
    logic [COUNT_WIDTH-1:0]     r_frame_total;
    logic [COUNT_WIDTH-1:0]     r_blocks;
    logic [LEVEL_W-1:0]         r_loud_abs;
    logic [COUNT_WIDTH-1:0]     r_loud_pos;

    logic                       accept;
    logic [CNT_W-1:0]           chans;
    logic [BSIZE_W-1:0]         bsize;
    logic [CH_W-1:0]            ch;
    logic signed [SAMPLE_W-1:0] v;
    logic [LEVEL_W-1:0]         mag;
    logic signed [SAMPLE_W-1:0] n_high_ch;
    logic signed [SAMPLE_W-1:0] n_low_ch;
    logic [LEVEL_W-1:0]         n_loud_abs;
    logic [COUNT_WIDTH-1:0]     n_loud_pos;
    logic [BSIZE_W-1:0]         n_fib;
    logic                       frame_done;
    logic                       block_end;
    logic [EXT_W-1:0]           ext_blocks;
    logic [EXT_W-1:0]           ext_pos;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // Clamp the configuration to the supported ranges.
    always_comb begin
        if (i_channel_count == '0) begin
            chans = CNT_W'(1);
        end else if (CMP_W'(i_channel_count) > CMP_W'(MAX_CHANNELS)) begin
            chans = CNT_W'(MAX_CHANNELS);
        end else begin
            chans = CNT_W'(i_channel_count);
        end
        bsize = (i_block_size == '0) ? BSIZE_W'(1) : i_block_size;
        ch    = (CNT_W'(r_ch) >= chans) ? CH_W'(chans - CNT_W'(1)) : r_ch;
    end

    assign v   = decode_sample(i_raw_sample, i_sample_bytes);
    assign mag = v[SAMPLE_W-1] ? (~LEVEL_W'(v) + LEVEL_W'(1)) : LEVEL_W'(v);

    always_comb begin
        if ((r_fib == '0) || (v > r_high[ch])) begin
            n_high_ch = v;
        end else begin
            n_high_ch = r_high[ch];
        end
        if ((r_fib == '0) || (v < r_low[ch])) begin
            n_low_ch = v;
        end else begin
            n_low_ch = r_low[ch];
        end
        if (mag > r_loud_abs) begin
            n_loud_abs = mag;
            n_loud_pos = r_frame_total;
        end else begin
            n_loud_abs = r_loud_abs;
            n_loud_pos = r_loud_pos;
        end
    end

    assign frame_done = ((CNT_W'(ch) + CNT_W'(1)) == chans);
    assign n_fib      = r_fib + BSIZE_W'(1);
    assign block_end  = frame_done && ((n_fib == '0) || (n_fib >= bsize));

    // Block record, including the update made by the closing sample.
    always_comb begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            o_high[i] = (CH_W'(i) == ch) ? n_high_ch : r_high[i];
            o_low[i]  = (CH_W'(i) == ch) ? n_low_ch  : r_low[i];
        end
    end

    assign ext_blocks           = EXT_W'(r_blocks);
    assign ext_pos              = EXT_W'(n_loud_pos);
    assign o_info.block_number  = ext_blocks[OUT_CNT_W-1:0];
    assign o_info.loudest_frame = ext_pos[OUT_CNT_W-1:0];
    assign o_info.loudest_level = n_loud_abs;
    assign o_chans              = chans;
    assign o_push               = accept && block_end;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_high[ch] <= n_high_ch;
            r_low[ch]  <= n_low_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fib         <= '0;
            r_ch          <= '0;
            r_frame_total <= '0;
            r_blocks      <= '0;
            r_loud_abs    <= '0;
            r_loud_pos    <= '0;
        end else if (accept) begin
            r_loud_abs <= n_loud_abs;
            r_loud_pos <= n_loud_pos;
            if (frame_done) begin
                r_ch          <= '0;
                r_frame_total <= r_frame_total + COUNT_WIDTH'(1);
                if (block_end) begin
                    r_fib    <= '0;
                    r_blocks <= r_blocks + COUNT_WIDTH'(1);
                end else begin
                    r_fib <= n_fib;
                end
            end else begin
                r_ch <= ch + CH_W'(1);
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/mmpd_back.sv
// Back part: walks the channels of a finished block and drives the result register.
`timescale 1ns / 1ps
`default_nettype none
module mmpd_back #(
    parameter int MAX_CHANNELS = 8,
    parameter int CNT_W        = $clog2(MAX_CHANNELS + 1)
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_empty,
    input  wire logic [MAX_CHANNELS-1:0][mmpd_pkg::SAMPLE_W-1:0] i_high,
    input  wire logic [MAX_CHANNELS-1:0][mmpd_pkg::SAMPLE_W-1:0] i_low,
    input  wire mmpd_pkg::t_blk_info                        i_info,
    input  wire logic [CNT_W-1:0]                           i_chans,
    output logic                                            o_pop,
    output logic                                            m_axis_tvalid,
    input  wire logic                                       m_axis_tready,
    output logic [mmpd_pkg::OUT_TDATA_W-1:0]                m_axis_tdata,
    output logic                                            m_axis_tlast
);
    import mmpd_pkg::*;

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [CH_W-1:0]          r_idx;
    logic                     r_valid;
    logic [OUT_FIELDS_W-1:0]  r_data;
    logic                     r_last;
    logic                     load;
    logic                     last_ch;

    assign load    = !i_empty && (!r_valid || m_axis_tready);
    assign last_ch = ((CNT_W'(r_idx) + CNT_W'(1)) >= i_chans);
    assign o_pop   = load && last_ch;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= {i_info.loudest_level, i_info.loudest_frame, i_info.block_number,
                       i_low[r_idx], i_high[r_idx], CHANNEL_W'(r_idx)};
            r_last <= last_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last_ch ? '0 : r_idx + CH_W'(1);
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_data);
    assign m_axis_tlast  = r_last;
endmodule
`default_nettype wire

// File: rtl/block_min_max_peak_detector_core.sv
// Top level of the block min/max peak detector with its configuration registers.
`timescale 1ns / 1ps
`default_nettype none
// The detector takes one interleaved PCM sample per item on the slave stream, channels in
// order within each frame, and accepts a new item in every clock cycle while the queue is
// not full. A front part decodes the sample (8-bit offset binary, 16-bit signed, or 24-bit
// signed scaled down by 256 toward zero), updates that channel's block maximum and minimum
// and the loudest level seen since reset, and when the last frame of a block completes it
// writes a snapshot of the whole block into a two-entry queue. A back part reads the queue
// and sends channel_count results, one per cycle while the master side is ready, from a
// registered output stage; tlast marks the final channel of each block. s_axis_tready drops
// only while the queue holds two finished blocks; the older one stays in the queue until
// its last channel result has been loaded into the output stage. With the master side ready
// the back part drains a block no slower than the front part can build the next one, so the
// sustained rate is one item per cycle. A trailing partial block produces no results.
// Configuration writes take effect at once and belong to idle periods; channel_count is
// clamped to 1..MAX_CHANNELS and a block_size of zero acts as one.
module block_min_max_peak_detector_core #(
    parameter int MAX_CHANNELS = mmpd_pkg::DEF_MAX_CHANNELS,
    parameter int COUNT_WIDTH  = mmpd_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration write port.
    input  wire logic                             i_cfg_we,
    input  wire logic [mmpd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mmpd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // Sample input.
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: raw_sample[23:0].
    input  wire logic [mmpd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Result output.
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata: channel[2:0], peak_high[18:3], peak_low[34:19], block_number[66:35],
    // loudest_frame[98:67], loudest_level[114:99], zero padding[119:115].
    output logic [mmpd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                  m_axis_tlast
);
    import mmpd_pkg::*;

    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int REC_W = CNT_W + $bits(t_blk_info) + 2 * MAX_CHANNELS * SAMPLE_W;
    localparam int ARR_W = MAX_CHANNELS * SAMPLE_W;

    logic [BSIZE_W-1:0]  r_block_size;
    logic [CHCFG_W-1:0]  r_channel_count;
    logic [SBYTES_W-1:0] r_sample_bytes;

    logic                                  q_full;
    logic                                  q_empty;
    logic                                  q_push;
    logic                                  q_pop;
    logic [REC_W-1:0]                      q_wdata;
    logic [REC_W-1:0]                      q_rdata;
    logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] f_high;
    logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] f_low;
    t_blk_info                             f_info;
    logic [CNT_W-1:0]                      f_chans;
    logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] b_high;
    logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] b_low;
    t_blk_info                             b_info;
    logic [CNT_W-1:0]                      b_chans;

    // Configuration registers; a write to an unused index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size    <= RST_BLOCK_SIZE;
            r_channel_count <= RST_CHANNEL_COUNT;
            r_sample_bytes  <= RST_SAMPLE_BYTES;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BLOCK_SIZE: begin
                    r_block_size <= i_cfg_wdata[BSIZE_W-1:0];
                end
                CFG_CHANNEL_COUNT: begin
                    r_channel_count <= i_cfg_wdata[CHCFG_W-1:0];
                end
                CFG_SAMPLE_BYTES: begin
                    r_sample_bytes <= i_cfg_wdata[SBYTES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    mmpd_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .CNT_W        (CNT_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_block_size    (r_block_size),
        .i_channel_count (r_channel_count),
        .i_sample_bytes  (r_sample_bytes),
        .i_valid         (s_axis_tvalid),
        .i_raw_sample    (s_axis_tdata[RAW_W-1:0]),
        .i_q_full        (q_full),
        .o_ready         (s_axis_tready),
        .o_push          (q_push),
        .o_high          (f_high),
        .o_low           (f_low),
        .o_info          (f_info),
        .o_chans         (f_chans)
    );

    // A block record travels through the queue as one flat word.
    assign q_wdata = {f_chans, f_info, f_high, f_low};

    mmpd_fifo #(
        .WIDTH (REC_W),
        .DEPTH (2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign b_low   = q_rdata[ARR_W-1:0];
    assign b_high  = q_rdata[2*ARR_W-1:ARR_W];
    assign b_info  = q_rdata[2*ARR_W+$bits(t_blk_info)-1:2*ARR_W];
    assign b_chans = q_rdata[REC_W-1:REC_W-CNT_W];

    mmpd_back #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CNT_W        (CNT_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_high        (b_high),
        .i_low         (b_low),
        .i_info        (b_info),
        .i_chans       (b_chans),
        .o_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );
endmodule
`default_nettype wire
